// File: sv/leaky_bucket_rate_limiter_macros.svh
// assertion helpers used by the checker file
`ifndef LEAKY_BUCKET_RATE_LIMITER_MACROS_SVH
`define LEAKY_BUCKET_RATE_LIMITER_MACROS_SVH

// clocked assertion, switched off while reset is held
`define LBRL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked assertion that also holds across reset
`define LBRL_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/lbrl_pkg.sv
package lbrl_pkg;

  // field and state widths
  localparam int unsigned LenW      = 24;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned RateW     = 32;
  localparam int unsigned LimW      = 32;
  localparam int unsigned FracW     = 16;
  localparam int unsigned LevelW    = 48;
  localparam int unsigned HalfW     = 24;
  localparam int unsigned ProdW     = HalfW + RateW;
  localparam int unsigned SumW      = LevelW + 1;
  localparam int unsigned DivW      = SumW;
  localparam int unsigned RelW      = TimeW + 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned VerdictW  = 2;

  // register indices
  localparam logic [CfgIdxW-1:0] CfgRate  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDrop  = 2'd2;

  // verdict codes
  localparam logic [VerdictW-1:0] VerdictPass  = 2'd0;
  localparam logic [VerdictW-1:0] VerdictDelay = 2'd1;
  localparam logic [VerdictW-1:0] VerdictDrop  = 2'd2;

  // register reset values
  localparam logic [RateW-1:0] RateReset  = 32'd65536;
  localparam logic [LimW-1:0]  LimitReset = 32'd65536;

  localparam logic [TimeW-1:0] TimeMax = '1;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic sync;
    logic mul_hi;
    logic mul_lo;
    logic drain;
    logic level;
    logic sum;
    logic fit;
    logic drop;
    logic stall_max;
    logic over;
    logic div_start;
    logic rel_add;
    logic rel_sat;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic exceed;
    logic drop_mode;
    logic rate_zero;
    logic div_done;
  } sts_t;

endpackage

// File: sv/leaky_bucket_rate_limiter.sv
// Leaky-bucket limiter on message sizes.
// Input channel (in_valid_i/in_ready_o) carries a message length and the
// current tick; output channel (out_valid_o/out_ready_i) returns one verdict
// per message (pass now, pass after delay, dropped) and its release tick.
// The configuration channel (cfg_valid_i/cfg_ready_o) writes rate, limit and
// drop mode; it is always ready and should be used only while no item is open.
// A delayed message takes longer to reach result valid than one that passes,
// is dropped or finds the rate zero, as its delay is set by the bit-serial
// divider (one quotient bit per cycle, 49 bits).
// One item is worked at a time: the next input transfer is taken at the earliest
// in the cycle after the result is loaded into the output register, so a new
// item can enter only once the previous one's result is loaded.
// A finished result sits in the output register while the receiver stalls;
// the next item is still accepted and processed, and waits for that register
// to be free before its own result is loaded.
// Reset empties the bucket, clears the synced flag and restores the
// registers to rate 1.0 byte per tick, limit 65536 bytes, delay mode.
module leaky_bucket_rate_limiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lbrl_pkg::LenW-1:0]     msg_len_i,
  input  logic [lbrl_pkg::TimeW-1:0]    now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lbrl_pkg::VerdictW-1:0] verdict_o,
  output logic [lbrl_pkg::TimeW-1:0]    release_time_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lbrl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lbrl_pkg::CfgDataW-1:0] cfg_data_i
);

  lbrl_pkg::cmd_t cmd;
  lbrl_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  lbrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic, limiter state and output register
  lbrl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .msg_len_i      (msg_len_i),
    .now_time_i     (now_time_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .verdict_o      (verdict_o),
    .release_time_o (release_time_o)
  );

endmodule

// File: sv/lbrl_div.sv
module lbrl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lbrl_pkg::DivW-1:0]     dividend_i,
  input  logic [lbrl_pkg::RateW-1:0]    divisor_i,
  output logic                          done_o,
  output logic [lbrl_pkg::DivW-1:0]     quotient_o,
  output logic                          rem_nz_o
);

  localparam int unsigned DivW  = lbrl_pkg::DivW;
  localparam int unsigned RateW = lbrl_pkg::RateW;
  localparam int unsigned CntW  = $clog2(DivW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] quo_q;
  logic [RateW-1:0] rem_q;
  logic [RateW:0]  trial;
  logic            fits;

  // one restoring step: bring down the next dividend bit
  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // quotient and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], fits};
      if (fits) begin
        rem_q <= RateW'(trial - {1'b0, divisor_i});
      end else begin
        rem_q <= trial[RateW-1:0];
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_nz_o   = |rem_q;

endmodule

// File: sv/lbrl_dp.sv
module lbrl_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [lbrl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lbrl_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [lbrl_pkg::LenW-1:0]       msg_len_i,
  input  logic [lbrl_pkg::TimeW-1:0]      now_time_i,
  input  lbrl_pkg::cmd_t                  cmd_i,
  output lbrl_pkg::sts_t                  sts_o,
  output logic [lbrl_pkg::VerdictW-1:0]   verdict_o,
  output logic [lbrl_pkg::TimeW-1:0]      release_time_o
);

  localparam int unsigned LenW     = lbrl_pkg::LenW;
  localparam int unsigned TimeW    = lbrl_pkg::TimeW;
  localparam int unsigned RateW    = lbrl_pkg::RateW;
  localparam int unsigned LimW     = lbrl_pkg::LimW;
  localparam int unsigned FracW    = lbrl_pkg::FracW;
  localparam int unsigned LevelW   = lbrl_pkg::LevelW;
  localparam int unsigned HalfW    = lbrl_pkg::HalfW;
  localparam int unsigned ProdW    = lbrl_pkg::ProdW;
  localparam int unsigned SumW     = lbrl_pkg::SumW;
  localparam int unsigned DivW     = lbrl_pkg::DivW;
  localparam int unsigned RelW     = lbrl_pkg::RelW;
  localparam int unsigned VerdictW = lbrl_pkg::VerdictW;

  // configuration
  logic [RateW-1:0]  rate_q;
  logic [LimW-1:0]   limit_q;
  logic              drop_q;

  // limiter state
  logic [LevelW-1:0] bucket_q;
  logic [TimeW-1:0]  last_q;
  logic              synced_q;

  // per-item working registers
  logic [LenW-1:0]   len_q;
  logic [TimeW-1:0]  now_q;
  logic [TimeW-1:0]  t_q;
  logic [TimeW-1:0]  elapsed_q;
  logic [ProdW-1:0]  prod_q;
  logic [HalfW-1:0]  hp_q;
  logic              hp_ovf_q;
  logic [LevelW-1:0] drain_q;
  logic [SumW-1:0]   sum_q;
  logic [DivW-1:0]   over_q;
  logic [RelW-1:0]   relsum_q;
  logic [VerdictW-1:0] res_verdict_q;
  logic [TimeW-1:0]  res_release_q;
  logic [VerdictW-1:0] out_verdict_q;
  logic [TimeW-1:0]  out_release_q;

  logic [LevelW-1:0] limq;
  logic [TimeW-1:0]  t_d;
  logic [TimeW-1:0]  elapsed_d;
  logic [HalfW-1:0]  mul_a;
  logic [ProdW-1:0]  prod_d;
  logic [ProdW:0]    dsum;
  logic [TimeW-1:0]  rel_d;
  logic              div_done;
  logic [DivW-1:0]   quotient;
  logic              rem_nz;

  assign limq = {limit_q, {FracW{1'b0}}};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= lbrl_pkg::RateReset;
      limit_q <= lbrl_pkg::LimitReset;
      drop_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lbrl_pkg::CfgRate:  rate_q  <= cfg_data_i[RateW-1:0];
        lbrl_pkg::CfgLimit: limit_q <= cfg_data_i[LimW-1:0];
        lbrl_pkg::CfgDrop:  drop_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sync time never moves back; first item drains nothing
  always_comb begin
    if (synced_q && (now_q < last_q)) begin
      t_d = last_q;
    end else begin
      t_d = now_q;
    end
    if (synced_q) begin
      elapsed_d = t_d - last_q;
    end else begin
      elapsed_d = '0;
    end
  end

  // shared multiplier, upper then lower half of the elapsed time
  assign mul_a  = cmd_i.mul_lo ? elapsed_q[HalfW-1:0] : elapsed_q[TimeW-1:HalfW];
  assign prod_d = ProdW'(mul_a) * ProdW'(rate_q);

  // recombine the partial products
  assign dsum = {{(ProdW + 1 - LevelW){1'b0}}, hp_q, {HalfW{1'b0}}} + {1'b0, prod_q};

  // saturated release time after a delay
  assign rel_d = (|relsum_q[RelW-1:TimeW]) ? lbrl_pkg::TimeMax : relsum_q[TimeW-1:0];

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q <= msg_len_i;
      now_q <= now_time_i;
    end
    if (cmd_i.sync) begin
      t_q       <= t_d;
      elapsed_q <= elapsed_d;
    end
    if (cmd_i.mul_hi || cmd_i.mul_lo) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mul_lo) begin
      hp_q     <= prod_q[HalfW-1:0];
      hp_ovf_q <= |prod_q[ProdW-1:HalfW];
    end
    if (cmd_i.drain) begin
      if (hp_ovf_q || (|dsum[ProdW:LevelW])) begin
        drain_q <= '1;
      end else begin
        drain_q <= dsum[LevelW-1:0];
      end
    end
    if (cmd_i.sum) begin
      sum_q <= {1'b0, bucket_q}
             + {{(SumW - LenW - FracW){1'b0}}, len_q, {FracW{1'b0}}};
    end
    if (cmd_i.over) begin
      over_q <= sum_q - {1'b0, limq};
    end
    if (cmd_i.rel_add) begin
      relsum_q <= {{(RelW - TimeW){1'b0}}, t_q}
                + {{(RelW - DivW){1'b0}}, quotient}
                + RelW'(rem_nz);
    end
    if (cmd_i.fit) begin
      res_verdict_q <= lbrl_pkg::VerdictPass;
      res_release_q <= now_q;
    end else if (cmd_i.drop) begin
      res_verdict_q <= lbrl_pkg::VerdictDrop;
      res_release_q <= now_q;
    end else if (cmd_i.stall_max) begin
      res_verdict_q <= lbrl_pkg::VerdictDelay;
      res_release_q <= lbrl_pkg::TimeMax;
    end else if (cmd_i.rel_sat) begin
      res_verdict_q <= lbrl_pkg::VerdictDelay;
      res_release_q <= rel_d;
    end
    if (cmd_i.out_load) begin
      out_verdict_q <= res_verdict_q;
      out_release_q <= res_release_q;
    end
  end

  // bucket level, sync time and synced flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q <= '0;
      last_q   <= '0;
      synced_q <= 1'b0;
    end else begin
      if (cmd_i.level) begin
        bucket_q <= (bucket_q > drain_q) ? bucket_q - drain_q : '0;
        last_q   <= t_q;
        synced_q <= 1'b1;
      end else if (cmd_i.fit) begin
        bucket_q <= sum_q[LevelW-1:0];
      end else if (cmd_i.stall_max) begin
        bucket_q <= limq;
        last_q   <= lbrl_pkg::TimeMax;
      end else if (cmd_i.rel_sat) begin
        bucket_q <= limq;
        last_q   <= rel_d;
      end
    end
  end

  // delay = ceil(overflow / rate)
  lbrl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (over_q),
    .divisor_i  (rate_q),
    .done_o     (div_done),
    .quotient_o (quotient),
    .rem_nz_o   (rem_nz)
  );

  // status to the controller
  assign sts_o.exceed    = sum_q > {1'b0, limq};
  assign sts_o.drop_mode = drop_q;
  assign sts_o.rate_zero = (rate_q == '0);
  assign sts_o.div_done  = div_done;

  assign verdict_o      = out_verdict_q;
  assign release_time_o = out_release_q;

endmodule

// File: sv/lbrl_ctrl.sv
module lbrl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  lbrl_pkg::sts_t sts_i,
  output lbrl_pkg::cmd_t cmd_o
);

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SSync    = 4'd1;
  localparam logic [3:0] SMulHi   = 4'd2;
  localparam logic [3:0] SMulLo   = 4'd3;
  localparam logic [3:0] SDrain   = 4'd4;
  localparam logic [3:0] SLevel   = 4'd5;
  localparam logic [3:0] SSum     = 4'd6;
  localparam logic [3:0] SDecide  = 4'd7;
  localparam logic [3:0] SDivGo   = 4'd8;
  localparam logic [3:0] SDivWait = 4'd9;
  localparam logic [3:0] SRelSat  = 4'd10;
  localparam logic [3:0] SDone    = 4'd11;

  logic [3:0] state_q;
  logic [3:0] state_d;
  logic       out_valid_q;

  // sequencing of one item
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SSync;
        end
      end
      SSync: begin
        cmd_o.sync = 1'b1;
        state_d    = SMulHi;
      end
      SMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = SMulLo;
      end
      SMulLo: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = SDrain;
      end
      SDrain: begin
        cmd_o.drain = 1'b1;
        state_d     = SLevel;
      end
      SLevel: begin
        cmd_o.level = 1'b1;
        state_d     = SSum;
      end
      SSum: begin
        cmd_o.sum = 1'b1;
        state_d   = SDecide;
      end
      SDecide: begin
        if (!sts_i.exceed) begin
          cmd_o.fit = 1'b1;
          state_d   = SDone;
        end else if (sts_i.drop_mode) begin
          cmd_o.drop = 1'b1;
          state_d    = SDone;
        end else if (sts_i.rate_zero) begin
          cmd_o.stall_max = 1'b1;
          state_d         = SDone;
        end else begin
          cmd_o.over = 1'b1;
          state_d    = SDivGo;
        end
      end
      SDivGo: begin
        cmd_o.div_start = 1'b1;
        state_d         = SDivWait;
      end
      SDivWait: begin
        if (sts_i.div_done) begin
          cmd_o.rel_add = 1'b1;
          state_d       = SRelSat;
        end
      end
      SRelSat: begin
        cmd_o.rel_sat = 1'b1;
        state_d       = SDone;
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/lbrl_checker.sv
`include "leaky_bucket_rate_limiter_macros.svh"

module lbrl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [lbrl_pkg::LenW-1:0]     msg_len_i,
  input logic [lbrl_pkg::TimeW-1:0]    now_time_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [lbrl_pkg::VerdictW-1:0] verdict_o,
  input logic [lbrl_pkg::TimeW-1:0]    release_time_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [lbrl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [lbrl_pkg::CfgDataW-1:0] cfg_data_i
);

  // a stalled result stays offered
  `LBRL_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result withdrawn")

  // a stalled result keeps its payload
  `LBRL_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(verdict_o) && $stable(release_time_o), "result changed while stalled")

  // nothing is offered straight after reset
  `LBRL_ASSERT_NR(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid after reset")

  // the block is busy in the cycle after an input transfer
  `LBRL_ASSERT(a_busy_after_in, in_valid_i && in_ready_o |=> !in_ready_o, "input taken twice")

  // a result never appears the cycle after an input transfer
  `LBRL_ASSERT(a_min_latency, $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o), "result too early")

endmodule

bind leaky_bucket_rate_limiter lbrl_checker u_lbrl_checker (.*);
